[src/utf8v_pkg.sv]
// shared types and constants of the strict utf-8 string checker
`default_nettype none

package utf8v_pkg;

    localparam int unsigned MAX_BYTES_W = 16;
    localparam int unsigned COUNT_W     = 17;
    localparam int unsigned ACC_W       = 21;
    localparam int unsigned PEND_W      = 2;
    localparam int unsigned SEQW_W      = 3;

    localparam logic [COUNT_W-1:0]     COUNT_MAX       = 17'h1FFFF;
    localparam logic [MAX_BYTES_W-1:0] MAX_BYTES_RESET = 16'd255;

    localparam logic [7:0] ASCII_TOP      = 8'h80;
    localparam logic [7:0] ASCII_CTRL_LIM = 8'h20;
    localparam logic [7:0] ASCII_DEL      = 8'h7F;
    localparam logic [7:0] LEAD2_MIN      = 8'hC2;
    localparam logic [7:0] LEAD2_MAX      = 8'hDF;
    localparam logic [7:0] LEAD3_MIN      = 8'hE0;
    localparam logic [7:0] LEAD3_MAX      = 8'hEF;
    localparam logic [7:0] LEAD4_MIN      = 8'hF0;
    localparam logic [7:0] LEAD4_MAX      = 8'hF4;

    localparam logic [ACC_W-1:0] CP_MAX       = 21'h10FFFF;
    localparam logic [ACC_W-1:0] SURR_MIN     = 21'h00D800;
    localparam logic [ACC_W-1:0] SURR_MAX     = 21'h00DFFF;
    localparam logic [ACC_W-1:0] NONCHAR_FFFE = 21'h00FFFE;
    localparam logic [ACC_W-1:0] NONCHAR_FFFF = 21'h00FFFF;
    localparam logic [ACC_W-1:0] MIN_CP2      = 21'h000080;
    localparam logic [ACC_W-1:0] MIN_CP3      = 21'h000800;
    localparam logic [ACC_W-1:0] MIN_CP4      = 21'h010000;

    localparam logic [SEQW_W-1:0] SEQ_NONE = 3'd0;
    localparam logic [SEQW_W-1:0] SEQ_TWO  = 3'd2;
    localparam logic [SEQW_W-1:0] SEQ_THREE = 3'd3;
    localparam logic [SEQW_W-1:0] SEQ_FOUR = 3'd4;

    localparam logic [1:0] CONT_TAG = 2'b10;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_string;
    } t_word;

    typedef struct packed {
        logic valid;
        logic valid_res;
    } t_res;

endpackage

`default_nettype wire

[src/utf8v_in_stage.sv]
// input register of the byte stream
`default_nettype none

module utf8v_in_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  [7:0]          i_data_byte,
    input  wire                 i_end_of_string,
    input  wire                 i_take,
    output logic                o_valid,
    output utf8v_pkg::t_word    o_word
);

    logic             r_valid;
    utf8v_pkg::t_word r_word;

    assign s_axis_tready = !r_valid || i_take;
    assign o_valid       = r_valid;
    assign o_word        = r_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_word.data_byte     <= i_data_byte;
            r_word.end_of_string <= i_end_of_string;
        end
    end

endmodule

`default_nettype wire

[src/utf8v_core.sv]
// running decode state, length check and verdict logic
`default_nettype none

module utf8v_core (
    input  wire                                    i_clk,
    input  wire                                    i_rst_n,
    input  wire                                    i_cfg_wr_en,
    input  wire  [utf8v_pkg::MAX_BYTES_W-1:0]      i_cfg_wr_data,
    input  wire                                    i_valid,
    input  utf8v_pkg::t_word                       i_word,
    input  wire                                    i_out_free,
    output logic                                   o_take,
    output utf8v_pkg::t_res                        o_res
);

    logic [utf8v_pkg::MAX_BYTES_W-1:0] r_max_bytes;
    logic [utf8v_pkg::PEND_W-1:0]      r_pend, n_pend;
    logic [utf8v_pkg::SEQW_W-1:0]      r_width, n_width;
    logic [utf8v_pkg::ACC_W-1:0]       r_acc, n_acc;
    logic                              r_err, n_err;
    logic [utf8v_pkg::COUNT_W-1:0]     r_count, n_count;

    logic [7:0]                        b;
    logic [utf8v_pkg::ACC_W-1:0]       acc_shift;
    logic [utf8v_pkg::PEND_W-1:0]      pend_dec;
    logic                              verdict;

    function automatic logic scalar_ok(
        input logic [utf8v_pkg::ACC_W-1:0]  cp,
        input logic [utf8v_pkg::SEQW_W-1:0] width
    );
        logic ok;
        ok = 1'b1;
        if (width == utf8v_pkg::SEQ_TWO && cp < utf8v_pkg::MIN_CP2) ok = 1'b0;
        if (width == utf8v_pkg::SEQ_THREE && cp < utf8v_pkg::MIN_CP3) ok = 1'b0;
        if (width == utf8v_pkg::SEQ_FOUR && cp < utf8v_pkg::MIN_CP4) ok = 1'b0;
        if (cp > utf8v_pkg::CP_MAX) ok = 1'b0;
        if (cp >= utf8v_pkg::SURR_MIN && cp <= utf8v_pkg::SURR_MAX) ok = 1'b0;
        if (cp == utf8v_pkg::NONCHAR_FFFE || cp == utf8v_pkg::NONCHAR_FFFF) ok = 1'b0;
        return ok;
    endfunction

    assign o_take = i_valid && (!i_word.end_of_string || i_out_free);
    assign b      = i_word.data_byte;

    always_comb begin
        n_pend    = r_pend;
        n_width   = r_width;
        n_acc     = r_acc;
        n_count   = (r_count == utf8v_pkg::COUNT_MAX) ? r_count
                                                      : r_count + 17'd1;
        n_err     = r_err | (n_count > {1'b0, r_max_bytes});
        acc_shift = {r_acc[utf8v_pkg::ACC_W-7:0], b[5:0]};
        pend_dec  = r_pend - 2'd1;

        if (!n_err) begin
            if (r_pend == 2'd0) begin
                priority if (b < utf8v_pkg::ASCII_TOP) begin
                    if (b < utf8v_pkg::ASCII_CTRL_LIM || b == utf8v_pkg::ASCII_DEL) begin
                        n_err = 1'b1;
                    end
                end else if (b >= utf8v_pkg::LEAD2_MIN && b <= utf8v_pkg::LEAD2_MAX) begin
                    n_acc   = {16'd0, b[4:0]};
                    n_width = utf8v_pkg::SEQ_TWO;
                    n_pend  = 2'd1;
                end else if (b >= utf8v_pkg::LEAD3_MIN && b <= utf8v_pkg::LEAD3_MAX) begin
                    n_acc   = {17'd0, b[3:0]};
                    n_width = utf8v_pkg::SEQ_THREE;
                    n_pend  = 2'd2;
                end else if (b >= utf8v_pkg::LEAD4_MIN && b <= utf8v_pkg::LEAD4_MAX) begin
                    n_acc   = {18'd0, b[2:0]};
                    n_width = utf8v_pkg::SEQ_FOUR;
                    n_pend  = 2'd3;
                end else begin
                    n_err = 1'b1;
                end
            end else if (b[7:6] != utf8v_pkg::CONT_TAG) begin
                n_err  = 1'b1;
                n_pend = 2'd0;
            end else begin
                n_acc  = acc_shift;
                n_pend = pend_dec;
                if (pend_dec == 2'd0) begin
                    if (!scalar_ok(acc_shift, r_width)) n_err = 1'b1;
                    n_width = utf8v_pkg::SEQ_NONE;
                    n_acc   = '0;
                end
            end
        end

        verdict = !n_err && (n_pend == 2'd0);

        if (i_word.end_of_string) begin
            n_pend  = '0;
            n_width = utf8v_pkg::SEQ_NONE;
            n_acc   = '0;
            n_err   = 1'b0;
            n_count = '0;
        end
    end

    assign o_res.valid     = o_take && i_word.end_of_string;
    assign o_res.valid_res = verdict;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_bytes <= utf8v_pkg::MAX_BYTES_RESET;
            r_pend      <= '0;
            r_width     <= utf8v_pkg::SEQ_NONE;
            r_acc       <= '0;
            r_err       <= 1'b0;
            r_count     <= '0;
        end else begin
            if (i_cfg_wr_en) r_max_bytes <= i_cfg_wr_data;
            if (o_take) begin
                r_pend  <= n_pend;
                r_width <= n_width;
                r_acc   <= n_acc;
                r_err   <= n_err;
                r_count <= n_count;
            end
        end
    end

    a_pend_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd0 |-> (r_width >= utf8v_pkg::SEQ_TWO && {1'b0, r_pend} < r_width))
        else $error("pending continuations outside sequence width");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend == 2'd0 && !r_err) |-> (r_width == utf8v_pkg::SEQ_NONE))
        else $error("sequence width left without pending bytes");

    a_clear_after_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_word.end_of_string) |=>
            (r_count == '0 && !r_err && r_pend == 2'd0 && r_acc == '0))
        else $error("string state not cleared after final byte");

    a_no_err_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> !r_err)
        else $error("error flag set with no bytes counted");

endmodule

`default_nettype wire

[src/utf8v_out_stage.sv]
// result register towards the verdict stream
`default_nettype none

module utf8v_out_stage (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  utf8v_pkg::t_res     i_res,
    output logic                o_free,
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    output logic [7:0]          m_axis_tdata
);

    logic r_valid;
    logic r_valid_res;

    assign o_free        = !r_valid || m_axis_tready;
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, r_valid_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_res.valid) r_valid_res <= i_res.valid_res;
    end

endmodule

`default_nettype wire

[src/utf8_single_line_validator_top.sv]
// a final byte's verdict word reaches m_axis through the input register, then the verdict register
// throughput: one byte per cycle; a final byte waits only while the verdict register is full and not read
// the ready path runs combinationally from m_axis_tready through the input register
// reset: synchronous active-low i_rst_n clears all string state and both stages
// reset: max_bytes returns to 255, a write to it is registered
`default_nettype none

module utf8_single_line_validator_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [15:0] i_cfg_wr_data,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire         s_axis_tlast,   // end_of_string
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] valid_res, [7:1] zero
);

    logic               word_valid;
    utf8v_pkg::t_word   word;
    logic               take;
    logic               out_free;
    utf8v_pkg::t_res    res;

    utf8v_in_stage u_in (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .i_data_byte    (s_axis_tdata),
        .i_end_of_string(s_axis_tlast),
        .i_take         (take),
        .o_valid        (word_valid),
        .o_word         (word)
    );

    utf8v_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_valid        (word_valid),
        .i_word         (word),
        .i_out_free     (out_free),
        .o_take         (take),
        .o_res          (res)
    );

    utf8v_out_stage u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_res          (res),
        .o_free         (out_free),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata)
    );

endmodule

`default_nettype wire

[sim/utf8_single_line_validator_top_tb.sv]
// testbench of the strict single-line utf-8 checker: byte strings in, verdicts checked
`timescale 1ns / 1ps

module utf8_single_line_validator_top_tb;

    localparam int QUIET_LIMIT = 1000;

    typedef enum int {
        F_CTRL, F_LEAD, F_OVERLONG, F_SURR, F_NONCHAR,
        F_RANGE, F_CUT, F_STRAY, F_NOISE, F_BROKEN
    } t_fault;

    class t_verdict_board;
        logic [utf8v_pkg::MAX_BYTES_W-1:0] max_len;
        logic [utf8v_pkg::PEND_W-1:0]      cont_left;
        logic [utf8v_pkg::SEQW_W-1:0]      seq_len;
        logic [utf8v_pkg::ACC_W-1:0]       cp_acc;
        bit                                bad;
        logic [utf8v_pkg::COUNT_W-1:0]     nbytes;
        bit                                verdicts_due[$];
        int                                fails;

        function new();
            max_len = utf8v_pkg::MAX_BYTES_RESET;
            fails = 0;
            clear_string();
        endfunction

        function void clear_string();
            cont_left = '0;
            seq_len = utf8v_pkg::SEQ_NONE;
            cp_acc = '0;
            bad = 1'b0;
            nbytes = '0;
        endfunction

        function bit scalar_legal(logic [utf8v_pkg::ACC_W-1:0] cp,
                                  logic [utf8v_pkg::SEQW_W-1:0] w);
            if (w == utf8v_pkg::SEQ_TWO && cp < utf8v_pkg::MIN_CP2) return 1'b0;
            if (w == utf8v_pkg::SEQ_THREE && cp < utf8v_pkg::MIN_CP3) return 1'b0;
            if (w == utf8v_pkg::SEQ_FOUR && cp < utf8v_pkg::MIN_CP4) return 1'b0;
            if (cp > utf8v_pkg::CP_MAX) return 1'b0;
            if (cp >= utf8v_pkg::SURR_MIN && cp <= utf8v_pkg::SURR_MAX) return 1'b0;
            if (cp == utf8v_pkg::NONCHAR_FFFE || cp == utf8v_pkg::NONCHAR_FFFF) return 1'b0;
            return 1'b1;
        endfunction

        function void decode(logic [7:0] b);
            if (cont_left == 0) begin
                if (b < utf8v_pkg::ASCII_TOP) begin
                    if (b < utf8v_pkg::ASCII_CTRL_LIM || b == utf8v_pkg::ASCII_DEL) bad = 1'b1;
                end else if (b >= utf8v_pkg::LEAD2_MIN && b <= utf8v_pkg::LEAD2_MAX) begin
                    cp_acc = {16'b0, b[4:0]};
                    seq_len = utf8v_pkg::SEQ_TWO;
                    cont_left = 2'd1;
                end else if (b >= utf8v_pkg::LEAD3_MIN && b <= utf8v_pkg::LEAD3_MAX) begin
                    cp_acc = {17'b0, b[3:0]};
                    seq_len = utf8v_pkg::SEQ_THREE;
                    cont_left = 2'd2;
                end else if (b >= utf8v_pkg::LEAD4_MIN && b <= utf8v_pkg::LEAD4_MAX) begin
                    cp_acc = {18'b0, b[2:0]};
                    seq_len = utf8v_pkg::SEQ_FOUR;
                    cont_left = 2'd3;
                end else begin
                    bad = 1'b1;
                end
            end else if (b[7:6] != utf8v_pkg::CONT_TAG) begin
                bad = 1'b1;
                cont_left = '0;
            end else begin
                cp_acc = {cp_acc[utf8v_pkg::ACC_W-7:0], b[5:0]};
                cont_left = cont_left - 2'd1;
                if (cont_left == 0) begin
                    if (!scalar_legal(cp_acc, seq_len)) bad = 1'b1;
                    seq_len = utf8v_pkg::SEQ_NONE;
                    cp_acc = '0;
                end
            end
        endfunction

        function void note_byte(utf8v_pkg::t_word w);
            if (nbytes != utf8v_pkg::COUNT_MAX) nbytes = nbytes + 1'b1;
            if (nbytes > {1'b0, max_len}) bad = 1'b1;
            if (!bad) decode(w.data_byte);
            if (w.end_of_string) begin
                verdicts_due.push_back(!bad && cont_left == 0);
                clear_string();
            end
        endfunction

        function int outstanding();
            return verdicts_due.size();
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            fails++;
        endtask

        task check_verdict(logic got);
            bit want;
            if (verdicts_due.size() == 0) begin
                report($sformatf("verdict %0b with none due", got));
                return;
            end
            want = verdicts_due.pop_front();
            if (got !== want) report($sformatf("valid_res %0b, want %0b", got, want));
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [15:0] i_cfg_wr_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // end_of_string
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [0] valid_res, [7:1] zero

    t_verdict_board board;
    logic [7:0]     str_q[$];
    bit             idle_on = 1'b1;
    int             quiet_cycles = 0;

    always #6 i_clk = ~i_clk;

    utf8_single_line_validator_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // utf-8 encoding of a code point at a forced width, overlong forms included
    function automatic void put_seq(logic [20:0] cp, int w);
        case (w)
            1: str_q.push_back({1'b0, cp[6:0]});
            2: begin
                str_q.push_back({3'b110, cp[10:6]});
                str_q.push_back({2'b10, cp[5:0]});
            end
            3: begin
                str_q.push_back({4'b1110, cp[15:12]});
                str_q.push_back({2'b10, cp[11:6]});
                str_q.push_back({2'b10, cp[5:0]});
            end
            default: begin
                str_q.push_back({5'b11110, cp[20:18]});
                str_q.push_back({2'b10, cp[17:12]});
                str_q.push_back({2'b10, cp[11:6]});
                str_q.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    function automatic void put_cp(logic [20:0] cp);
        put_seq(cp, cp < 21'h80 ? 1 : cp < 21'h800 ? 2 : cp < 21'h10000 ? 3 : 4);
    endfunction

    function automatic void add_char(bit faulty);
        int          pick;
        int          w;
        logic [20:0] cp;
        t_fault      fault;
        if (faulty && $urandom_range(0, 3) == 0) begin
            fault = t_fault'($urandom_range(0, F_BROKEN));
            w = $urandom_range(2, 4);
            case (fault)
                F_CTRL: str_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(0, 31))
                                                            : utf8v_pkg::ASCII_DEL);
                F_LEAD: str_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hC1))
                                                            : 8'($urandom_range(8'hF5, 8'hFF)));
                F_OVERLONG: put_seq(21'($urandom_range(0, w == 2 ? 21'h7F : w == 3 ? 21'h7FF
                                                                         : 21'hFFFF)), w);
                F_SURR:    put_seq(21'($urandom_range(utf8v_pkg::SURR_MIN,
                                                      utf8v_pkg::SURR_MAX)), 3);
                F_NONCHAR: put_seq(21'($urandom_range(utf8v_pkg::NONCHAR_FFFE,
                                                      utf8v_pkg::NONCHAR_FFFF)), 3);
                F_RANGE:   put_seq(21'($urandom_range(utf8v_pkg::CP_MAX + 1, 21'h1FFFFF)), 4);
                F_CUT: begin
                    put_seq(21'(w == 2 ? $urandom_range(21'h80, 21'h7FF)
                              : w == 3 ? $urandom_range(21'h800, 21'hD7FF)
                              : $urandom_range(21'h10000, utf8v_pkg::CP_MAX)), w);
                    repeat ($urandom_range(1, w - 1)) void'(str_q.pop_back());
                end
                F_STRAY: str_q.push_back(8'($urandom_range(8'h80, 8'hBF)));
                F_NOISE: str_q.push_back(8'($urandom_range(0, 255)));
                default: begin
                    str_q.push_back(8'($urandom_range(utf8v_pkg::LEAD2_MIN,
                                                      utf8v_pkg::LEAD4_MAX)));
                    str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
                end
            endcase
            return;
        end
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            put_cp(21'($urandom_range(8'h20, 8'h7E)));
        end else if (pick < 55) begin
            put_cp(21'($urandom_range(21'h80, 21'h7FF)));
        end else if (pick < 72) begin
            do cp = 21'($urandom_range(21'h800, 21'hFFFF));
            while ((cp >= utf8v_pkg::SURR_MIN && cp <= utf8v_pkg::SURR_MAX)
                   || cp >= utf8v_pkg::NONCHAR_FFFE);
            put_cp(cp);
        end else if (pick < 88) begin
            put_cp(21'($urandom_range(21'h10000, utf8v_pkg::CP_MAX)));
        end else begin
            case ($urandom_range(0, 7))
                0: cp = utf8v_pkg::MIN_CP2;
                1: cp = utf8v_pkg::MIN_CP3 - 21'd1;
                2: cp = utf8v_pkg::MIN_CP3;
                3: cp = utf8v_pkg::SURR_MIN - 21'd1;
                4: cp = utf8v_pkg::SURR_MAX + 21'd1;
                5: cp = utf8v_pkg::NONCHAR_FFFE - 21'd1;
                6: cp = utf8v_pkg::MIN_CP4;
                default: cp = utf8v_pkg::CP_MAX;
            endcase
            put_cp(cp);
        end
    endfunction

    function automatic void build_string();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 6)) str_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 8)) add_char(kind >= 68);
        end
    endfunction

    task automatic send_byte(logic [7:0] b, bit last);
        int               gap;
        utf8v_pkg::t_word w;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        repeat (gap) @(negedge i_clk) s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        w.data_byte = b;
        w.end_of_string = last;
        board.note_byte(w);
    endtask

    task automatic send_string();
        int n;
        n = str_q.size();
        for (int k = 0; k < n; k++) send_byte(str_q[k], k == n - 1);
        str_q.delete();
    endtask

    task automatic wait_idle();
        @(negedge i_clk) s_axis_tvalid <= 1'b0;
        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_max(logic [15:0] v);
        wait_idle();
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(negedge i_clk) i_cfg_wr_en <= 1'b0;
        board.max_len = v;
    endtask

    // verdict side: random stall before each word while idle_on is set
    initial begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = idle_on ? $urandom_range(0, 5) : 0;
            repeat (gap) @(negedge i_clk) m_axis_tready <= 1'b0;
            @(negedge i_clk) m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (m_axis_tvalid !== 1'b1);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            board.check_verdict(m_axis_tdata[0]);
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready === 1'b1) || (m_axis_tvalid === 1'b1 && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("utf8_single_line_validator_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        logic [15:0] caps[8];
        int          sent;
        caps = '{16'hFFFF, 16'd1, 16'd3, 16'd7, 16'd12, 16'd0, 16'd255, 16'd20};
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        board = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        str_q = '{8'h20, 8'h7E};             send_string();
        str_q = '{8'h00};                    send_string();
        str_q = '{8'h7F};                    send_string();
        str_q = '{8'hC2, 8'h80};             send_string();
        str_q = '{8'hF4, 8'h8F, 8'hBF, 8'hBF}; send_string();
        // overlong, surrogate, noncharacter, beyond the last code point
        str_q = '{8'hE0, 8'h9F, 8'hBF};      send_string();
        str_q = '{8'hED, 8'hA0, 8'h80};      send_string();
        str_q = '{8'hEF, 8'hBF, 8'hBE};      send_string();
        str_q = '{8'hF4, 8'h90, 8'h80, 8'h80}; send_string();
        // ascii byte where a continuation is due, then a sequence cut off, then an illegal lead byte
        str_q = '{8'hC3, 8'h41};             send_string();
        str_q = '{8'hE2};                    send_string();
        str_q = '{8'hFF};                    send_string();
        set_max(16'd1);
        str_q = '{8'h41, 8'h42};             send_string();
        set_max(16'd0);
        str_q = '{8'h41};                    send_string();

        foreach (caps[p]) begin
            set_max(caps[p]);
            sent = 0;
            while (sent < 90) begin
                build_string();
                idle_on = $urandom_range(0, 3) != 0;
                sent += str_q.size();
                send_string();
            end
        end

        // longest string allowed and one byte over
        set_max(16'd24);
        idle_on = 1'b0;
        repeat (24) str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        send_string();
        repeat (25) str_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
        send_string();
        idle_on = 1'b1;

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (board.fails == 0)
            $display("utf8_single_line_validator_top_tb OK");
        else
            $display("utf8_single_line_validator_top_tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
src/utf8v_pkg.sv
src/utf8v_in_stage.sv
src/utf8v_core.sv
src/utf8v_out_stage.sv
src/utf8_single_line_validator_top.sv
sim/utf8_single_line_validator_top_tb.sv
